### src/hpq_pkg.sv
package hpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [KEY_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  removed_value;
    logic signed [KEY_W-1:0]  top_value;
    logic [COUNT_W-1:0]       entry_count;
    status_t                  status;
  } out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [KEY_W-1:0]  key;
  } cell_cmd_t;

endpackage

### src/hpq_cell.sv
module hpq_cell
  import hpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_cmd_t                cmd,
  input  logic signed [KEY_W-1:0]  left_val,
  input  logic                     left_vld,
  input  logic                     left_ge,
  input  logic signed [KEY_W-1:0]  right_val,
  input  logic                     right_vld,
  output logic signed [KEY_W-1:0]  val,
  output logic                     vld,
  output logic                     ge
);

  logic signed [KEY_W-1:0] val_r, val_nxt;
  logic                    vld_r, vld_nxt;

  // This cell holds a key at least as large as the one being inserted.
  assign ge = vld_r && (val_r >= cmd.key);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (cmd.ins) begin
      if (!ge) begin
        // The key lands here when the left neighbor keeps its own entry,
        // otherwise shift the left neighbor's entry in.
        val_nxt = left_ge ? cmd.key : left_val;
        vld_nxt = vld_r | left_vld;
      end
    end else if (cmd.del) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

### src/max_heap_priority_queue_top.sv
// Max-priority queue of signed 32-bit keys.
//
// Input channel: drive in_req and raise start; a request is taken at a rising
// edge with start high and busy low. busy stays low: the queue takes one
// request in every cycle. operation OP_INSERT adds in_req.value, OP_DELETE
// removes the largest key.
//
// Result channel: every request gives one result, shown on out_res for exactly
// one cycle with out_valid high, in the cycle right after the request was taken
// (throughput 1 request per cycle). The receiver cannot stall
// and must take the result in that cycle. The result carries the removed key,
// the new maximum (zero when empty), the entry count and a status: delete on
// an empty queue reports ST_EMPTY, insert on a full queue reports ST_FULL and
// drops the key; neither changes the contents.
//
// Storage is a row of CAPACITY cells kept sorted largest first. An insert
// makes every cell compare against the key and the smaller entries shift right
// past it; a delete shifts every cell left by one. Cell 0 always holds the max.
// Reset clears all valid bits and the count; the queue starts empty.
module max_heap_priority_queue_top
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_req,
  output logic out_valid,
  output out_t out_res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic signed [KEY_W-1:0] removed_r, removed_nxt;
  status_t                 status_r, status_nxt;

  cell_cmd_t               cmd;
  logic                    accept;
  logic                    full;
  logic                    empty;

  logic signed [KEY_W-1:0] cell_val [CAPACITY];
  logic                    cell_vld [CAPACITY];
  logic                    cell_ge  [CAPACITY];

  // Take a request every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // Decode the request; drop operations that would break the queue.
  always_comb begin
    cmd.key     = in_req.value;
    cmd.ins     = 1'b0;
    cmd.del     = 1'b0;
    count_nxt   = count_r;
    removed_nxt = '0;
    status_nxt  = ST_DONE;
    if (accept) begin
      unique case (in_req.operation)
        OP_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DELETE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.del     = 1'b1;
            count_nxt   = count_r - 1'b1;
            removed_nxt = cell_val[0];
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  // Sorted chain: left neighbor of cell 0 is a virtual always-larger entry,
  // right neighbor of the last cell is empty.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] lval, rval;
    logic                    lvld, lge, rvld;

    if (i == 0) begin : g_first
      assign lval = '0;
      assign lvld = 1'b1;
      assign lge  = 1'b1;
    end else begin : g_mid
      assign lval = cell_val[i-1];
      assign lvld = cell_vld[i-1];
      assign lge  = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_inner
      assign rval = cell_val[i+1];
      assign rvld = cell_vld[i+1];
    end

    hpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_val  (lval),
      .left_vld  (lvld),
      .left_ge   (lge),
      .right_val (rval),
      .right_vld (rvld),
      .val       (cell_val[i]),
      .vld       (cell_vld[i]),
      .ge        (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result reads the chain head and count as left by the request.
  assign out_valid             = out_valid_r;
  assign out_res.removed_value = removed_r;
  assign out_res.top_value     = cell_vld[0] ? cell_val[0] : '0;
  assign out_res.entry_count   = COUNT_W'(count_r);
  assign out_res.status        = status_r;

endmodule
